### src/ihcv_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the image header validator.
package ihcv_pkg;

  localparam int HDR_BYTES_DEF   = 12;
  localparam int ENTRY_BYTES_DEF = 4;

  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  // Fixed header layout, byte offsets.
  localparam logic [15:0] HDR_MAGIC_END   = 16'd4;
  localparam logic [15:0] HDR_VERSION_POS = 16'd4;
  localparam logic [15:0] HDR_COUNT_POS   = 16'd5;
  localparam logic [15:0] HDR_CLEN_LO_POS = 16'd6;
  localparam logic [15:0] HDR_CLEN_HI_POS = 16'd7;
  localparam logic [15:0] HDR_CRC_POS     = 16'd8;
  localparam logic [15:0] HDR_CRC_END     = 16'd12;

  // Byte slots inside an event entry that hold the code offset.
  localparam int OFFSET_LO_PART = 2;
  localparam int OFFSET_HI_PART = 3;

  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    REG_MAGIC_WORD   = 2'd0,
    REG_FORMAT_VER   = 2'd1,
    REG_EVENT_LIMIT  = 2'd2,
    REG_IMAGE_LIMIT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CAUSE_NONE    = 3'd0,
    CAUSE_SHORT   = 3'd1,
    CAUSE_MAGIC   = 3'd2,
    CAUSE_VERSION = 3'd3,
    CAUSE_COUNT   = 3'd4,
    CAUSE_LENGTH  = 3'd5,
    CAUSE_CRC     = 3'd6,
    CAUSE_OFFSET  = 3'd7
  } fault_cause_t;

  typedef struct packed {
    logic [15:0]  code_start;
    logic [15:0]  code_length;
    logic [7:0]   event_total;
    fault_cause_t fault_cause;
    logic         image_ok;
  } result_t;

  // Reflected CRC-32 update for one byte; unrolls into a single XOR network.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### src/image_header_crc_validator_unit.sv
// Image header validator: header field checks, CRC-32 over the body and event offset checks.
// The verdict for the in_tlast byte is registered in out_r, or in the skid stage while stalled.
// Throughput: one image byte per cycle while the skid stage is empty; the CRC and field checks
// sit between the state registers and the result register, and a one-entry skid stage behind the
// result register lets input continue while a result waits.
// Reset: rst_n is synchronous, active low; it loads register defaults and clears all stream state.
module image_header_crc_validator_unit #(
  parameter int HEADER_BYTES = ihcv_pkg::HDR_BYTES_DEF,
  parameter int ENTRY_BYTES  = ihcv_pkg::ENTRY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] image_ok, [3:1] fault_cause, [11:4] event_total, [27:12] code_length,
  // [43:28] code_start, [47:44] zero
  output logic [ihcv_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import ihcv_pkg::*;

  localparam int PART_W = $clog2(ENTRY_BYTES);
  localparam int LEN_W  = 17;
  localparam int EXP_W  = $clog2(HEADER_BYTES + 255 * ENTRY_BYTES + 65536);

  // Configuration registers.
  logic [31:0] magic_word_r;
  logic [7:0]  format_version_r;
  logic [7:0]  event_limit_r;
  logic [15:0] image_size_limit_r;

  // Stream state.
  logic [15:0]       pos_r;
  logic              ovf_r;
  logic [31:0]       crc_r,    crc_nxt;
  logic [31:0]       rcrc_r,   rcrc_nxt;
  logic [7:0]        count_r,  count_nxt;
  logic [15:0]       clen_r,   clen_nxt;
  logic [7:0]        off_lo_r, off_lo_nxt;
  logic              magic_bad_r, magic_bad_nxt;
  logic              ver_bad_r,   ver_bad_nxt;
  logic              off_bad_r,   off_bad_nxt;
  logic [PART_W-1:0] part_r,   part_nxt;
  logic [8:0]        entry_r,  entry_nxt;

  // Result register and skid stage.
  result_t out_r, skid_r, res;
  logic    out_valid_r, skid_valid_r;

  logic            in_fire;
  logic            res_valid;
  logic [LEN_W-1:0] len;
  logic [EXP_W-1:0] table_end;
  logic [EXP_W-1:0] expected;
  fault_cause_t     cause;
  logic [7:0]       magic_byte;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign res_valid = in_fire && in_tlast;

  assign magic_byte = 8'(magic_word_r >> {pos_r[1:0], 3'b000});

  // Per-byte update of the header fields, CRC and event table checks.
  always_comb begin
    crc_nxt       = crc_r;
    rcrc_nxt      = rcrc_r;
    count_nxt     = count_r;
    clen_nxt      = clen_r;
    off_lo_nxt    = off_lo_r;
    magic_bad_nxt = magic_bad_r;
    ver_bad_nxt   = ver_bad_r;
    off_bad_nxt   = off_bad_r;
    part_nxt      = part_r;
    entry_nxt     = entry_r;
    if (!ovf_r) begin
      if (pos_r < HDR_MAGIC_END) begin
        if (magic_byte != in_tdata) begin
          magic_bad_nxt = 1'b1;
        end
      end else if (pos_r == HDR_VERSION_POS) begin
        if (in_tdata != format_version_r) begin
          ver_bad_nxt = 1'b1;
        end
      end else if (pos_r == HDR_COUNT_POS) begin
        count_nxt = in_tdata;
      end else if (pos_r == HDR_CLEN_LO_POS) begin
        clen_nxt[7:0] = in_tdata;
      end else if (pos_r == HDR_CLEN_HI_POS) begin
        clen_nxt[15:8] = in_tdata;
      end else if (pos_r >= HDR_CRC_POS && pos_r < HDR_CRC_END) begin
        rcrc_nxt[{pos_r[1:0], 3'b000} +: 8] = in_tdata;
      end

      if (pos_r >= 16'(HEADER_BYTES)) begin
        crc_nxt = crc_byte(crc_r, in_tdata);
        if (entry_r < {1'b0, count_r}) begin
          if (part_r == PART_W'(OFFSET_LO_PART)) begin
            off_lo_nxt = in_tdata;
          end else if (part_r == PART_W'(OFFSET_HI_PART)) begin
            if ({in_tdata, off_lo_r} >= clen_r) begin
              off_bad_nxt = 1'b1;
            end
          end
        end
        if (part_r == PART_W'(ENTRY_BYTES - 1)) begin
          part_nxt = '0;
          // Saturates above any possible event count.
          if (!entry_r[8]) begin
            entry_nxt = entry_r + 9'd1;
          end
        end else begin
          part_nxt = part_r + PART_W'(1);
        end
      end
    end
  end

  // Final checks on the state as it stands after the last byte.
  assign len       = ovf_r ? LEN_W'(17'h10000) : ({1'b0, pos_r} + LEN_W'(1));
  assign table_end = EXP_W'(HEADER_BYTES) + EXP_W'(count_nxt) * EXP_W'(ENTRY_BYTES);
  assign expected  = table_end + EXP_W'(clen_nxt);

  always_comb begin
    priority if (len < LEN_W'(HEADER_BYTES + ENTRY_BYTES)) begin
      cause = CAUSE_SHORT;
    end else if (magic_bad_nxt) begin
      cause = CAUSE_MAGIC;
    end else if (ver_bad_nxt) begin
      cause = CAUSE_VERSION;
    end else if (count_nxt == 8'd0 || count_nxt > event_limit_r) begin
      cause = CAUSE_COUNT;
    end else if (len[16] || expected != EXP_W'(len) ||
                 len[15:0] > image_size_limit_r) begin
      cause = CAUSE_LENGTH;
    end else if (rcrc_nxt != (crc_nxt ^ CRC_PRESET)) begin
      cause = CAUSE_CRC;
    end else if (off_bad_nxt) begin
      cause = CAUSE_OFFSET;
    end else begin
      cause = CAUSE_NONE;
    end
  end

  always_comb begin
    res.image_ok    = (cause == CAUSE_NONE);
    res.fault_cause = cause;
    if (cause == CAUSE_NONE) begin
      res.event_total = count_nxt;
      res.code_length = clen_nxt;
      res.code_start  = 16'(table_end);
    end else begin
      res.event_total = '0;
      res.code_length = '0;
      res.code_start  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r       <= '0;
      format_version_r   <= 8'd1;
      event_limit_r      <= 8'd16;
      image_size_limit_r <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAGIC_WORD:  magic_word_r       <= cfg_wdata;
        REG_FORMAT_VER:  format_version_r   <= cfg_wdata[7:0];
        REG_EVENT_LIMIT: event_limit_r      <= cfg_wdata[7:0];
        REG_IMAGE_LIMIT: image_size_limit_r <= cfg_wdata[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      crc_r       <= CRC_PRESET;
      rcrc_r      <= '0;
      count_r     <= '0;
      clen_r      <= '0;
      off_lo_r    <= '0;
      magic_bad_r <= 1'b0;
      ver_bad_r   <= 1'b0;
      off_bad_r   <= 1'b0;
      part_r      <= '0;
      entry_r     <= '0;
    end else if (in_fire) begin
      if (!ovf_r) begin
        if (pos_r == 16'hFFFF) begin
          ovf_r <= 1'b1;
        end else begin
          pos_r <= pos_r + 16'd1;
        end
      end
      crc_r       <= crc_nxt;
      rcrc_r      <= rcrc_nxt;
      count_r     <= count_nxt;
      clen_r      <= clen_nxt;
      off_lo_r    <= off_lo_nxt;
      magic_bad_r <= magic_bad_nxt;
      ver_bad_r   <= ver_bad_nxt;
      off_bad_r   <= off_bad_nxt;
      part_r      <= part_nxt;
      entry_r     <= entry_nxt;
    end
  end

  // The skid entry only fills while the result register is stalled, and input
  // stops as soon as it holds a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_r);

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (pos_r == 16'd0 && !ovf_r && crc_r == CRC_PRESET))
    else $error("stream state not cleared after the last byte");

  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (!out_valid_r || out_tready) && !skid_valid_r) |=> out_valid_r)
    else $error("result of the last byte did not reach the output register");

  a_ok_matches_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.image_ok == (out_r.fault_cause == CAUSE_NONE)))
    else $error("image_ok disagrees with fault_cause");
`endif

endmodule

### verif/image_header_crc_validator_unit_tb.sv
// Self-checking testbench for the image header validator: random and directed images.
`timescale 1ns / 1ps

module image_header_crc_validator_unit_tb;
  import ihcv_pkg::*;

  localparam int QUIET_LIMIT = 3000;

  // Predicts one verdict per image and checks the block's results against them in order.
  class VerdictPredictor;
    logic [31:0] magic;
    logic [7:0]  version;
    logic [7:0]  max_events;
    logic [15:0] max_size;

    logic [15:0] pos;
    bit          saturated;
    logic [31:0] crc;
    logic [31:0] stored_crc;
    logic [7:0]  n_events;
    logic [15:0] clen;
    logic [7:0]  off_lo;
    bit          bad_magic, bad_version, bad_offset;

    result_t verdicts[$];
    int      errors;

    function new();
      magic      = 32'd0;
      version    = 8'd1;
      max_events = 8'd16;
      max_size   = 16'd4096;
      errors     = 0;
      restart();
    endfunction

    // Bit-serial form of the reflected CRC-32: one data bit enters per shift.
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
        r = (r >> 1) ^ ((r[0] ^ d[i]) ? CRC_POLY : 32'h0);
      end
      return r;
    endfunction

    function void restart();
      pos         = 16'd0;
      saturated   = 1'b0;
      crc         = CRC_PRESET;
      stored_crc  = 32'd0;
      n_events    = 8'd0;
      clen        = 16'd0;
      off_lo      = 8'd0;
      bad_magic   = 1'b0;
      bad_version = 1'b0;
      bad_offset  = 1'b0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [31:0] v);
      case (idx)
        REG_MAGIC_WORD:  magic = v;
        REG_FORMAT_VER:  version = v[7:0];
        REG_EVENT_LIMIT: max_events = v[7:0];
        REG_IMAGE_LIMIT: max_size = v[15:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic is_last);
      int unsigned idx, rel, len, want;
      fault_cause_t cause;
      result_t r;
      idx = pos;
      if (!saturated) begin
        if (idx < HDR_MAGIC_END) begin
          if (magic[8*idx +: 8] != b) bad_magic = 1'b1;
        end else if (idx == HDR_VERSION_POS) begin
          if (b != version) bad_version = 1'b1;
        end else if (idx == HDR_COUNT_POS) begin
          n_events = b;
        end else if (idx == HDR_CLEN_LO_POS) begin
          clen[7:0] = b;
        end else if (idx == HDR_CLEN_HI_POS) begin
          clen[15:8] = b;
        end else if (idx < HDR_CRC_END) begin
          stored_crc[8*(idx - HDR_CRC_POS) +: 8] = b;
        end
        if (idx >= HDR_BYTES_DEF) begin
          rel = idx - HDR_BYTES_DEF;
          crc = crc_step(crc, b);
          // Only entries inside the declared event count carry offsets.
          if (rel / ENTRY_BYTES_DEF < n_events) begin
            if (rel % ENTRY_BYTES_DEF == OFFSET_LO_PART) begin
              off_lo = b;
            end else if (rel % ENTRY_BYTES_DEF == OFFSET_HI_PART) begin
              if ({b, off_lo} >= clen) bad_offset = 1'b1;
            end
          end
        end
      end
      len = saturated ? 32'h10000 : idx + 1;
      if (!saturated) begin
        if (pos == 16'hFFFF) saturated = 1'b1;
        else pos = pos + 16'd1;
      end
      if (!is_last) return;

      want = HDR_BYTES_DEF + n_events * ENTRY_BYTES_DEF + clen;
      if (len < HDR_BYTES_DEF + ENTRY_BYTES_DEF) cause = CAUSE_SHORT;
      else if (bad_magic) cause = CAUSE_MAGIC;
      else if (bad_version) cause = CAUSE_VERSION;
      else if (n_events < 1 || n_events > max_events) cause = CAUSE_COUNT;
      else if (len > 32'hFFFF || want != len || len > max_size) cause = CAUSE_LENGTH;
      else if (stored_crc != (crc ^ CRC_PRESET)) cause = CAUSE_CRC;
      else if (bad_offset) cause = CAUSE_OFFSET;
      else cause = CAUSE_NONE;

      r = '0;
      r.image_ok    = (cause == CAUSE_NONE);
      r.fault_cause = cause;
      if (cause == CAUSE_NONE) begin
        r.event_total = n_events;
        r.code_length = clen;
        r.code_start  = 16'(HDR_BYTES_DEF + n_events * ENTRY_BYTES_DEF);
      end
      verdicts.push_back(r);
      restart();
    endfunction

    function void compare_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", label, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(logic [OUT_DATA_W-1:0] word);
      result_t want, got;
      got = word[$bits(result_t)-1:0];
      if (verdicts.size() == 0) begin
        $error("result with no image pending: %h", word);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      compare_field("image_ok", want.image_ok, got.image_ok);
      compare_field("fault_cause", want.fault_cause, got.fault_cause);
      compare_field("event_total", want.event_total, got.event_total);
      compare_field("code_length", want.code_length, got.code_length);
      compare_field("code_start", want.code_start, got.code_start);
      compare_field("pad", 0, word[OUT_DATA_W-1:$bits(result_t)]);
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_MAGIC_WORD;
  logic [31:0] cfg_wdata = 32'd0;

  VerdictPredictor sb = new();

  logic [7:0] image_bytes[$];
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  image_header_crc_validator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Receiver back-pressure in random bursts.
  always @(posedge clk) begin
    if (rx_calm) begin
      out_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else if ($urandom_range(7) == 0) begin
      out_tready <= 1'b0;
      rx_hold = $urandom_range(8, 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Handshake monitor: feeds the predictor, checks results and runs the watchdog.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_verdict(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b, logic is_last);
    if (!tx_calm && $urandom_range(7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_image();
    for (int i = 0; i < image_bytes.size(); i++) begin
      push_byte(image_bytes[i], i == image_bytes.size() - 1);
    end
  endtask

  // Stop sending and wait until every verdict is back and the block is idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Narrow registers get random upper bits, which the block must drop.
  task automatic apply_settings(logic [31:0] magic, logic [7:0] ver, logic [7:0] lim,
                                logic [15:0] size);
    logic [31:0] words[4];
    logic [31:0] junk;
    cfg_reg_t idx;
    junk = $urandom();
    words[REG_MAGIC_WORD]  = magic;
    words[REG_FORMAT_VER]  = {junk[31:8], ver};
    words[REG_EVENT_LIMIT] = {junk[23:0], lim};
    words[REG_IMAGE_LIMIT] = {junk[15:0], size};
    cfg_we <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      idx = cfg_reg_t'(k);
      cfg_index <= idx;
      cfg_wdata <= words[k];
      sb.set_register(idx, words[k]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Well-formed image under the current settings; entry bad_entry gets an offset past the code.
  function automatic void make_image(int n_ev, int clen, int bad_entry);
    logic [31:0] crc;
    logic [15:0] off;
    logic [15:0] len16;
    len16 = 16'(clen);
    image_bytes.delete();
    for (int i = 0; i < 4; i++) image_bytes.push_back(sb.magic[8*i +: 8]);
    image_bytes.push_back(sb.version);
    image_bytes.push_back(8'(n_ev));
    image_bytes.push_back(len16[7:0]);
    image_bytes.push_back(len16[15:8]);
    repeat (4) image_bytes.push_back(8'd0);
    for (int i = HDR_CRC_END; i < HDR_BYTES_DEF; i++) image_bytes.push_back(8'($urandom));
    for (int e = 0; e < n_ev; e++) begin
      if (e == bad_entry || clen == 0) off = 16'($urandom_range(16'hFFFF, clen));
      else if ($urandom_range(3) == 0) off = 16'(clen - 1);
      else off = 16'($urandom_range(clen - 1, 0));
      image_bytes.push_back(8'($urandom));
      image_bytes.push_back(8'($urandom));
      image_bytes.push_back(off[7:0]);
      image_bytes.push_back(off[15:8]);
      for (int j = 4; j < ENTRY_BYTES_DEF; j++) image_bytes.push_back(8'($urandom));
    end
    repeat (clen) image_bytes.push_back(8'($urandom));
    crc = CRC_PRESET;
    for (int i = HDR_BYTES_DEF; i < image_bytes.size(); i++) begin
      crc = VerdictPredictor::crc_step(crc, image_bytes[i]);
    end
    crc = crc ^ CRC_PRESET;
    for (int i = 0; i < 4; i++) image_bytes[HDR_CRC_POS + i] = crc[8*i +: 8];
  endfunction

  // Mostly well-formed images with random content, the rest with one kind of damage.
  function automatic void random_image();
    int kind, ev_cap, n_ev, room, clen, bad, cut;
    logic [7:0] flip;
    kind   = $urandom_range(99);
    flip   = 8'(1 << $urandom_range(7));
    ev_cap = (sb.max_events == 0) ? 1 : ((sb.max_events > 4) ? 4 : int'(sb.max_events));
    n_ev   = $urandom_range(ev_cap, 1);
    room   = int'(sb.max_size) - HDR_BYTES_DEF - ENTRY_BYTES_DEF * n_ev;
    if (room >= 600 && $urandom_range(32) == 0) clen = $urandom_range(600, 256);
    else clen = $urandom_range((room > 12) ? 12 : ((room < 1) ? 1 : room), 1);
    bad = (kind >= 91 && kind <= 94) ? $urandom_range(n_ev - 1) : -1;
    if (kind >= 77 && kind <= 79) n_ev = 0;
    else if (kind >= 80 && kind <= 82) n_ev = (sb.max_events == 255) ? 0 : sb.max_events + 1;
    make_image(n_ev, clen, bad);
    if (kind >= 70 && kind <= 73) begin
      cut = $urandom_range(3);
      image_bytes[cut] = image_bytes[cut] ^ flip;
    end else if (kind >= 74 && kind <= 76) begin
      image_bytes[HDR_VERSION_POS] = image_bytes[HDR_VERSION_POS] ^ flip;
    end else if (kind >= 83 && kind <= 86) begin
      if ($urandom_range(1)) image_bytes.push_back(8'($urandom));
      else void'(image_bytes.pop_back());
    end else if (kind >= 87 && kind <= 90) begin
      cut = $urandom_range(image_bytes.size() - 1, HDR_CRC_POS);
      image_bytes[cut] = image_bytes[cut] ^ flip;
    end else if (kind >= 95 && kind <= 97) begin
      cut = $urandom_range(HDR_BYTES_DEF + ENTRY_BYTES_DEF - 1, 1);
      while (image_bytes.size() > cut) void'(image_bytes.pop_back());
    end else if (kind >= 98) begin
      image_bytes.delete();
      repeat ($urandom_range(40, 1)) image_bytes.push_back(8'($urandom));
    end
  endfunction

  task automatic run_random(int budget, bit tail);
    int sent;
    sent = 0;
    while (sent < budget) begin
      if (tail && sent * 10 > budget * 6) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end else begin
        tx_calm = ($urandom_range(3) == 0);
        rx_calm = ($urandom_range(3) == 0);
      end
      random_image();
      sent += image_bytes.size();
      send_image();
      if (!tail && $urandom_range(24) == 0) settle();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed images under the reset settings.
    image_bytes.delete();
    image_bytes.push_back(8'hFF);
    send_image();
    make_image(1, 1, -1);
    send_image();
    make_image(16, 3, -1);
    send_image();
    make_image(2, 2, 1);
    send_image();
    make_image(0, 5, -1);
    send_image();
    make_image(17, 1, -1);
    send_image();
    make_image(1, 4, -1);
    image_bytes[image_bytes.size() - 1] = ~image_bytes[image_bytes.size() - 1];
    send_image();
    make_image(1, 4, -1);
    image_bytes.push_back(8'h00);
    send_image();
    make_image(1, 4, -1);
    while (image_bytes.size() > HDR_BYTES_DEF + ENTRY_BYTES_DEF - 1) begin
      void'(image_bytes.pop_back());
    end
    send_image();
    // Magic and version both wrong: magic takes priority.
    make_image(1, 4, -1);
    image_bytes[0] = ~image_bytes[0];
    image_bytes[HDR_VERSION_POS] = ~image_bytes[HDR_VERSION_POS];
    send_image();
    make_image(1, 4, -1);
    image_bytes[HDR_VERSION_POS] = ~image_bytes[HDR_VERSION_POS];
    send_image();
    settle();

    // Image length right at the size limit, then one byte over it.
    apply_settings(32'h0000_0000, 8'h01, 8'd16, 16'd40);
    make_image(1, 40 - HDR_BYTES_DEF - ENTRY_BYTES_DEF, -1);
    send_image();
    make_image(1, 40 - HDR_BYTES_DEF - ENTRY_BYTES_DEF + 1, -1);
    send_image();
    settle();

    apply_settings(32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF);
    make_image(30, 2, -1);
    send_image();
    run_random(150, 1'b0);
    settle();

    apply_settings($urandom(), 8'h00, 8'd1, 16'd4096);
    run_random(150, 1'b0);
    settle();

    apply_settings(32'h0000_0000, 8'($urandom), 8'($urandom_range(20, 2)), 16'd16);
    run_random(60, 1'b0);
    settle();

    // A zero event limit rejects every image.
    apply_settings($urandom(), 8'($urandom), 8'd0, 16'hFFFF);
    run_random(40, 1'b0);
    settle();

    apply_settings($urandom(), 8'($urandom), 8'($urandom_range(20, 2)),
                   16'($urandom_range(4096, 64)));
    run_random(350, 1'b1);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
